/* sv/oadc_pkg.sv */
// Obstacle-avoid drive controller: shared constants, register map and types.
// No dependencies; imported by oadc_apb_regs, the top level and the bench.
`default_nettype none

package oadc_pkg;

    localparam int COUNTER_BITS = 16;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_OBSTACLE = 3'd0;
    localparam logic [2:0] REG_CORNER   = 3'd1;
    localparam logic [2:0] REG_STUCK    = 3'd2;
    localparam logic [2:0] REG_ESCAPE   = 3'd3;
    localparam logic [2:0] REG_TURN     = 3'd4;
    localparam logic [2:0] REG_CRUISE   = 3'd5;

    localparam logic [15:0] RST_OBSTACLE = 16'd10;
    localparam logic [15:0] RST_CORNER   = 16'd12;
    localparam logic [15:0] RST_STUCK    = 16'd2000;
    localparam logic [15:0] RST_ESCAPE   = 16'd3000;
    localparam logic [9:0]  RST_TURN     = 10'd600;
    localparam logic [9:0]  RST_CRUISE   = 10'd400;

    localparam logic [2:0] ACT_FWD   = 3'd0;
    localparam logic [2:0] ACT_BACK  = 3'd1;
    localparam logic [2:0] ACT_LEFT  = 3'd2;
    localparam logic [2:0] ACT_RIGHT = 3'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    localparam logic [2:0] DIR_F = 3'd0;
    localparam logic [2:0] DIR_B = 3'd1;
    localparam logic [2:0] DIR_L = 3'd2;
    localparam logic [2:0] DIR_R = 3'd3;
    localparam logic [2:0] DIR_S = 3'd4;

    typedef struct packed {
        logic [15:0] obstacle_limit_cm;
        logic [15:0] corner_limit_cm;
        logic [15:0] stuck_time_ms;
        logic [15:0] escape_time_ms;
        logic [9:0]  turn_speed;
        logic [9:0]  cruise_speed;
    } t_cfg;

    typedef logic [COUNTER_BITS-1:0] t_cnt;

    // speed * 100 / 1023, truncated; x/1024 undershoots by at most one
    function automatic logic [6:0] speed_to_percent(input logic [9:0] spd);
        logic [16:0] x;
        logic [6:0]  q0;
        logic [10:0] rem;
        x   = {1'b0, spd, 6'b0} + {2'b0, spd, 5'b0} + {5'b0, spd, 2'b0};
        q0  = x[16:10];
        rem = {1'b0, x[9:0]} + {4'b0, q0};
        return (rem >= 11'd1023) ? q0 + 7'd1 : q0;
    endfunction

endpackage

`default_nettype wire

/* sv/oadc_apb_regs.sv */
// Obstacle-avoid drive controller: APB configuration register file.
// Depends on oadc_pkg for the register map, reset values and t_cfg.
`default_nettype none

module oadc_apb_regs
    import oadc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_limit_cm <= RST_OBSTACLE;
            r_cfg.corner_limit_cm   <= RST_CORNER;
            r_cfg.stuck_time_ms     <= RST_STUCK;
            r_cfg.escape_time_ms    <= RST_ESCAPE;
            r_cfg.turn_speed        <= RST_TURN;
            r_cfg.cruise_speed      <= RST_CRUISE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_OBSTACLE: r_cfg.obstacle_limit_cm <= pwdata[15:0];
                REG_CORNER:   r_cfg.corner_limit_cm   <= pwdata[15:0];
                REG_STUCK:    r_cfg.stuck_time_ms     <= pwdata[15:0];
                REG_ESCAPE:   r_cfg.escape_time_ms    <= pwdata[15:0];
                REG_TURN:     r_cfg.turn_speed        <= pwdata[9:0];
                REG_CRUISE:   r_cfg.cruise_speed      <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OBSTACLE: prdata = {16'd0, r_cfg.obstacle_limit_cm};
            REG_CORNER:   prdata = {16'd0, r_cfg.corner_limit_cm};
            REG_STUCK:    prdata = {16'd0, r_cfg.stuck_time_ms};
            REG_ESCAPE:   prdata = {16'd0, r_cfg.escape_time_ms};
            REG_TURN:     prdata = {22'd0, r_cfg.turn_speed};
            REG_CRUISE:   prdata = {22'd0, r_cfg.cruise_speed};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/obstacle_avoid_drive_controller_unit.sv */
// Obstacle-avoid drive controller, top level: input register, decision logic,
// stuck timer, direction counters and result register. Uses oadc_pkg, oadc_apb_regs.
//
//  channel  | handshake          | contents
//  ---------+--------------------+---------------------------------------------
//  input    | i_valid / o_stall  | cmd, left/front/right cm, now_ms
//  result   | o_valid / i_stall  | action, letter, speed, percent, 4 counters
//  config   | APB psel/penable   | six limit and speed registers
//
// One word per cycle while no stalled result holds the flow.
// The decision, timer and counter update sit between the input register and
// the result register; state is updated as a word moves into the result register.
// Synchronous active-low reset clears valids, stuck state, letter and counters.
// A stalled result holds; the input register keeps accepting until it too is full.
`default_nettype none

module obstacle_avoid_drive_controller_unit
    import oadc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_cmd,
    input  wire logic [15:0]          i_left_cm,
    input  wire logic [15:0]          i_front_cm,
    input  wire logic [15:0]          i_right_cm,
    input  wire logic [31:0]          i_now_ms,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic      [2:0]           o_motor_action,
    output logic      [2:0]           o_reported_dir,
    output logic      [9:0]           o_drive_speed,
    output logic      [6:0]           o_speed_percent,
    output logic      [15:0]          o_forward_count,
    output logic      [15:0]          o_backward_count,
    output logic      [15:0]          o_left_count,
    output logic      [15:0]          o_right_count,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready
);

    t_cfg cfg;

    oadc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [15:0] r_in_left;
    logic [15:0] r_in_front;
    logic [15:0] r_in_right;
    logic [31:0] r_in_now;

    // state
    logic        r_stuck;
    logic [31:0] r_since;
    logic [2:0]  r_prev_dir;
    t_cnt        r_cnt [4];

    // result register
    logic        r_out_valid;
    logic [2:0]  r_out_act;
    logic [2:0]  r_out_dir;
    logic [9:0]  r_out_spd;
    logic [6:0]  r_out_pct;

    logic        in_accept;
    logic        advance;

    logic        n_stuck;
    logic [31:0] n_since;
    logic [2:0]  n_prev_dir;
    t_cnt        n_cnt [4];
    logic [2:0]  n_act;
    logic [2:0]  n_dir;
    logic [9:0]  n_spd;

    logic        om, ol, orr, any_obs, stuck_now, corner;
    logic [31:0] since_now;
    logic [31:0] elapsed;

    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign advance   = r_in_valid && !(r_out_valid && i_stall);
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        om        = r_in_front <= cfg.obstacle_limit_cm;
        ol        = r_in_left  <= cfg.obstacle_limit_cm;
        orr       = r_in_right <= cfg.obstacle_limit_cm;
        any_obs   = om || ol || orr;
        corner    = (r_in_left <= cfg.corner_limit_cm) && (r_in_right <= cfg.corner_limit_cm);
        stuck_now = any_obs;
        since_now = (any_obs && !r_stuck) ? r_in_now : r_since;
        elapsed   = r_in_now - since_now;

        n_stuck    = r_stuck;
        n_since    = r_since;
        n_prev_dir = r_prev_dir;
        for (int k = 0; k < 4; k++) n_cnt[k] = r_cnt[k];
        n_act = ACT_NONE;
        n_dir = DIR_S;
        n_spd = '0;

        if (r_in_cmd) begin
            for (int k = 0; k < 4; k++) n_cnt[k] = '0;
            n_prev_dir = DIR_S;
        end else begin
            n_stuck = stuck_now;
            n_since = since_now;
            n_spd   = cfg.turn_speed;
            if (stuck_now && (elapsed >= {16'd0, cfg.stuck_time_ms})) begin
                n_act = ACT_BACK;
                n_dir = DIR_B;
                if (elapsed >= {16'd0, cfg.escape_time_ms}) n_stuck = 1'b0;
            end else if (corner) begin
                n_act = ACT_BACK;
                n_dir = DIR_B;
            end else if (om && ol) begin
                n_act = ACT_RIGHT;
                n_dir = DIR_L;
            end else if (om && orr) begin
                n_act = ACT_LEFT;
                n_dir = DIR_R;
            end else if (om) begin
                if (r_in_left > r_in_right) begin
                    n_act = ACT_LEFT;
                    n_dir = DIR_R;
                end else begin
                    n_act = ACT_RIGHT;
                    n_dir = DIR_L;
                end
            end else if (ol) begin
                n_act = ACT_RIGHT;
                n_dir = DIR_L;
            end else if (orr) begin
                n_act = ACT_LEFT;
                n_dir = DIR_R;
            end else begin
                n_act = ACT_FWD;
                n_dir = DIR_F;
                n_spd = cfg.cruise_speed;
            end
            // count only on a change of letter
            if (n_dir != r_prev_dir) begin
                n_cnt[n_dir[1:0]] = r_cnt[n_dir[1:0]] + t_cnt'(1);
                n_prev_dir        = n_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd   <= i_cmd;
            r_in_left  <= i_left_cm;
            r_in_front <= i_front_cm;
            r_in_right <= i_right_cm;
            r_in_now   <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_stuck     <= 1'b0;
            r_since     <= '0;
            r_prev_dir  <= DIR_S;
            for (int k = 0; k < 4; k++) r_cnt[k] <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_stuck     <= n_stuck;
            r_since     <= n_since;
            r_prev_dir  <= n_prev_dir;
            for (int k = 0; k < 4; k++) r_cnt[k] <= n_cnt[k];
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_act <= n_act;
            r_out_dir <= n_dir;
            r_out_spd <= n_spd;
            r_out_pct <= speed_to_percent(n_spd);
        end
    end

    logic [31:0] cnt_ext [4];
    always_comb begin
        for (int k = 0; k < 4; k++) cnt_ext[k] = 32'(r_cnt[k]);
    end

    assign o_valid          = r_out_valid;
    assign o_motor_action   = r_out_act;
    assign o_reported_dir   = r_out_dir;
    assign o_drive_speed    = r_out_spd;
    assign o_speed_percent  = r_out_pct;
    assign o_forward_count  = cnt_ext[0][15:0];
    assign o_backward_count = cnt_ext[1][15:0];
    assign o_left_count     = cnt_ext[2][15:0];
    assign o_right_count    = cnt_ext[3][15:0];

    // stall only when both stages hold a word
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // a clear word shows zero speed and zeroed counters
    a_clear_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_act == ACT_NONE) |->
            (r_out_dir == DIR_S && r_out_spd == '0 && r_cnt[0] == '0 && r_cnt[1] == '0
             && r_cnt[2] == '0 && r_cnt[3] == '0))
        else $error("clear word with non-zero payload");

    // swapped letters: right turn reports L (left turn reports R, which this check does not cover)
    a_letters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_act == ACT_RIGHT) |-> r_out_dir == DIR_L)
        else $error("right turn not reported as L");

    // a drive word always leaves a real letter behind
    a_prev_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_cmd) |=> (r_prev_dir != DIR_S))
        else $error("letter still S after a drive word");

    // stuck state only moves with a word
    a_stuck_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_stuck))
        else $error("stuck flag changed without a word");

    a_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pct <= 7'd100))
        else $error("percent above 100");

endmodule

`default_nettype wire

/* sim/obstacle_avoid_drive_controller_unit_tb.sv */
// Self-checking bench for obstacle_avoid_drive_controller_unit: a scripted table
// followed by random drive scenes under several limit settings.
// Depends on oadc_pkg and the controller RTL only.
`default_nettype none

module obstacle_avoid_drive_controller_unit_tb;
    import oadc_pkg::*;

    localparam int PHASE_WORDS    = 75;
    localparam int NUM_SETTINGS   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  dir;
        logic [9:0]  speed;
        logic [6:0]  pct;
        logic [15:0] fwd_cnt;
        logic [15:0] back_cnt;
        logic [15:0] left_cnt;
        logic [15:0] right_cnt;
    } t_drive_res;

    typedef struct {
        bit          cmd;
        logic [15:0] left_cm;
        logic [15:0] front_cm;
        logic [15:0] right_cm;
        logic [31:0] now_ms;
        bit          typed;
        t_drive_res  res;
    } t_script_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_cmd = 1'b0;
    logic [15:0]          i_left_cm = '0;
    logic [15:0]          i_front_cm = '0;
    logic [15:0]          i_right_cm = '0;
    logic [31:0]          i_now_ms = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [2:0]           o_motor_action;
    logic [2:0]           o_reported_dir;
    logic [9:0]           o_drive_speed;
    logic [6:0]           o_speed_percent;
    logic [15:0]          o_forward_count;
    logic [15:0]          o_backward_count;
    logic [15:0]          o_left_count;
    logic [15:0]          o_right_count;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    obstacle_avoid_drive_controller_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_left_cm        (i_left_cm),
        .i_front_cm       (i_front_cm),
        .i_right_cm       (i_right_cm),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_motor_action   (o_motor_action),
        .o_reported_dir   (o_reported_dir),
        .o_drive_speed    (o_drive_speed),
        .o_speed_percent  (o_speed_percent),
        .o_forward_count  (o_forward_count),
        .o_backward_count (o_backward_count),
        .o_left_count     (o_left_count),
        .o_right_count    (o_right_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 i_clk = ~i_clk;

    // controller copy: limits and steering state
    t_cfg                    limits;
    bit                      stuck;
    logic [31:0]             stuck_origin;
    logic [2:0]              prev_letter;
    logic [COUNTER_BITS-1:0] dir_cnt [0:3];

    t_drive_res  drive_results_due [$];
    t_script_row script_rows [$];

    bit          word_typed_on = 1'b0;
    t_drive_res  word_typed = '0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          stall_level = 1'b0;
    int          stall_run = 0;

    int          mismatches = 0;
    int          results_seen = 0;
    int          words_sent = 0;
    int          settings_done = 0;
    int          idle_cycles = 0;

    t_drive_res  got_res;
    t_drive_res  want_res;

    logic [31:0]  ms_now;
    int unsigned  step_max;
    logic [2:0]   scene_mask;
    int           scene_left;
    int           row_idx;
    int           phase;
    int           n;
    bit           rnd_cmd;

    function automatic t_drive_res mk_res(input logic [2:0] act, input logic [2:0] dir,
                                          input logic [9:0] spd, input logic [6:0] pct,
                                          input logic [15:0] f, input logic [15:0] b,
                                          input logic [15:0] l, input logic [15:0] r);
        t_drive_res res;
        res = '{act, dir, spd, pct, f, b, l, r};
        return res;
    endfunction

    function automatic string fmt_res(input t_drive_res res);
        return $sformatf("act %0d dir %0d spd %0d pct %0d f/b/L/r %0d/%0d/%0d/%0d",
                         res.action, res.dir, res.speed, res.pct,
                         res.fwd_cnt, res.back_cnt, res.left_cnt, res.right_cnt);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic reset_controller_copy();
        limits.obstacle_limit_cm = RST_OBSTACLE;
        limits.corner_limit_cm   = RST_CORNER;
        limits.stuck_time_ms     = RST_STUCK;
        limits.escape_time_ms    = RST_ESCAPE;
        limits.turn_speed        = RST_TURN;
        limits.cruise_speed      = RST_CRUISE;
        stuck        = 1'b0;
        stuck_origin = '0;
        prev_letter  = DIR_S;
        for (int k = 0; k < 4; k++) begin
            dir_cnt[k] = '0;
        end
    endtask

    // one steering decision, updates the stuck timer and letter counters
    function automatic t_drive_res steer_step(input bit cmd, input logic [15:0] l,
                                              input logic [15:0] m, input logic [15:0] r,
                                              input logic [31:0] now);
        t_drive_res  res;
        bit          om;
        bit          ol;
        bit          orr;
        logic [31:0] elapsed;
        logic [2:0]  act;
        logic [2:0]  dir;
        logic [9:0]  spd;
        int unsigned pct;
        if (cmd) begin
            for (int k = 0; k < 4; k++) begin
                dir_cnt[k] = '0;
            end
            prev_letter = DIR_S;
            act = ACT_NONE;
            dir = DIR_S;
            spd = '0;
        end else begin
            om  = m <= limits.obstacle_limit_cm;
            ol  = l <= limits.obstacle_limit_cm;
            orr = r <= limits.obstacle_limit_cm;
            if (om || ol || orr) begin
                if (!stuck) begin
                    stuck = 1'b1;
                    stuck_origin = now;
                end
            end else begin
                stuck = 1'b0;
            end
            elapsed = now - stuck_origin;
            spd = limits.turn_speed;
            if (stuck && elapsed >= {16'd0, limits.stuck_time_ms}) begin
                act = ACT_BACK;
                dir = DIR_B;
                if (elapsed >= {16'd0, limits.escape_time_ms}) begin
                    stuck = 1'b0;
                end
            end else if (l <= limits.corner_limit_cm && r <= limits.corner_limit_cm) begin
                act = ACT_BACK;
                dir = DIR_B;
            end else if (om && ol) begin
                act = ACT_RIGHT;
                dir = DIR_L;
            end else if (om && orr) begin
                act = ACT_LEFT;
                dir = DIR_R;
            end else if (om) begin
                if (l > r) begin
                    act = ACT_LEFT;
                    dir = DIR_R;
                end else begin
                    act = ACT_RIGHT;
                    dir = DIR_L;
                end
            end else if (ol) begin
                act = ACT_RIGHT;
                dir = DIR_L;
            end else if (orr) begin
                act = ACT_LEFT;
                dir = DIR_R;
            end else begin
                act = ACT_FWD;
                dir = DIR_F;
                spd = limits.cruise_speed;
            end
            if (dir != prev_letter) begin
                if (dir != DIR_S) begin
                    dir_cnt[dir] = dir_cnt[dir] + 1'b1;
                end
                prev_letter = dir;
            end
        end
        pct = (32'(spd) * 100) / 1023;
        res.action    = act;
        res.dir       = dir;
        res.speed     = spd;
        res.pct       = 7'(pct);
        res.fwd_cnt   = 16'(dir_cnt[DIR_F]);
        res.back_cnt  = 16'(dir_cnt[DIR_B]);
        res.left_cnt  = 16'(dir_cnt[DIR_L]);
        res.right_cnt = 16'(dir_cnt[DIR_R]);
        return res;
    endfunction

    // accepted words feed the controller copy; accepted results are checked in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want_res = steer_step(i_cmd, i_left_cm, i_front_cm, i_right_cm, i_now_ms);
                drive_results_due.push_back(word_typed_on ? word_typed : want_res);
                words_sent++;
            end
            if (o_valid && !i_stall) begin
                got_res = '{o_motor_action, o_reported_dir, o_drive_speed, o_speed_percent,
                            o_forward_count, o_backward_count, o_left_count, o_right_count};
                results_seen++;
                if (drive_results_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected result: %s", fmt_res(got_res)));
                end else begin
                    want_res = drive_results_due.pop_front();
                    if (got_res !== want_res) begin
                        note_mismatch($sformatf("result %0d: expected %s, got %s",
                                                results_seen, fmt_res(want_res),
                                                fmt_res(got_res)));
                    end
                end
            end
        end
    end

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 2);
        end else if (r < 92) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(12, 40);
    endfunction

    always @(negedge i_clk) begin
        if (!stalls_on) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_level = ~stall_level;
                stall_run = stall_level ? pick_len() : pick_len() + $urandom_range(0, 4);
            end
            stall_run--;
            i_stall <= stall_level;
        end
    end

    task automatic send_word(input bit cmd, input logic [15:0] l, input logic [15:0] m,
                             input logic [15:0] r, input logic [31:0] now,
                             input bit typed, input t_drive_res res);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 1)) begin
            gap = pick_len();
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_left_cm     <= l;
        i_front_cm    <= m;
        i_right_cm    <= r;
        i_now_ms      <= now;
        word_typed_on <= typed;
        word_typed    <= res;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic stop_words();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain(input int settle);
        while (drive_results_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // write one register, read it back, and mirror it in the controller copy
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        mask = (idx == REG_TURN || idx == REG_CRUISE) ? 32'h0000_03FF : 32'h0000_FFFF;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (value & mask)) begin
            note_mismatch($sformatf("register %0d: wrote %h, read %h", idx, value & mask, got));
        end
        case (idx)
            REG_OBSTACLE: limits.obstacle_limit_cm = value[15:0];
            REG_CORNER:   limits.corner_limit_cm   = value[15:0];
            REG_STUCK:    limits.stuck_time_ms     = value[15:0];
            REG_ESCAPE:   limits.escape_time_ms    = value[15:0];
            REG_TURN:     limits.turn_speed        = value[9:0];
            REG_CRUISE:   limits.cruise_speed      = value[9:0];
            default: ;
        endcase
    endtask

    task automatic load_limits(input logic [31:0] obst, input logic [31:0] corner,
                               input logic [31:0] stuck_ms, input logic [31:0] escape_ms,
                               input logic [31:0] turn, input logic [31:0] cruise);
        set_reg(REG_OBSTACLE, obst);
        set_reg(REG_CORNER, corner);
        set_reg(REG_STUCK, stuck_ms);
        set_reg(REG_ESCAPE, escape_ms);
        set_reg(REG_TURN, turn);
        set_reg(REG_CRUISE, cruise);
        settings_done++;
    endtask

    // distances biased towards the current limits
    function automatic logic [15:0] pick_dist(input bit near);
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return limits.obstacle_limit_cm;
            3: return limits.obstacle_limit_cm + 16'd1;
            4: return limits.corner_limit_cm;
            5: return limits.corner_limit_cm + 16'd1;
            default: begin
                if (near) begin
                    return 16'($urandom_range(0, 32'(limits.obstacle_limit_cm)));
                end else if (limits.obstacle_limit_cm == 16'hFFFF) begin
                    return 16'($urandom);
                end
                return 16'($urandom_range(32'(limits.obstacle_limit_cm) + 1, 65535));
            end
        endcase
    endfunction

    task automatic add_row(input bit cmd, input logic [15:0] l, input logic [15:0] m,
                           input logic [15:0] r, input logic [31:0] now,
                           input bit typed, input t_drive_res res);
        t_script_row row;
        row = '{cmd, l, m, r, now, typed, res};
        script_rows.push_back(row);
    endtask

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("obstacle_avoid_drive_controller_unit_tb NOT OK");
        $finish;
    end

    initial begin
        reset_controller_copy();
        // first step after reset, boxed in, clear
        add_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1,
                mk_res(ACT_FWD, DIR_F, 10'd400, 7'd39, 16'd1, 16'd0, 16'd0, 16'd0));
        add_row(1'b0, 16'd0, 16'd0, 16'd0, 32'd100, 1'b1,
                mk_res(ACT_BACK, DIR_B, 10'd600, 7'd58, 16'd1, 16'd1, 16'd0, 16'd0));
        add_row(1'b1, 16'd0, 16'd0, 16'd0, 32'd150, 1'b1,
                mk_res(ACT_NONE, DIR_S, 10'd0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        // front blocked, tie and each side; then side and paired obstacles
        add_row(1'b0, 16'd100, 16'd5, 16'd100, 32'd200, 1'b0, '0);
        add_row(1'b0, 16'd200, 16'd5, 16'd100, 32'd300, 1'b0, '0);
        add_row(1'b0, 16'd10, 16'd100, 16'd100, 32'd400, 1'b0, '0);
        add_row(1'b0, 16'd100, 16'd100, 16'd10, 32'd500, 1'b0, '0);
        add_row(1'b0, 16'd5, 16'd5, 16'd100, 32'd600, 1'b0, '0);
        add_row(1'b0, 16'd100, 16'd5, 16'd5, 32'd700, 1'b0, '0);
        // corner without obstacle, then forward twice (no count on repeat)
        add_row(1'b0, 16'd12, 16'd100, 16'd12, 32'd800, 1'b0, '0);
        add_row(1'b0, 16'd13, 16'd11, 16'd11, 32'd900, 1'b0, '0);
        add_row(1'b0, 16'd13, 16'd11, 16'd11, 32'd950, 1'b0, '0);
        // stuck timer: just short, reverse, escape, restart
        add_row(1'b0, 16'd1000, 16'd0, 16'd1000, 32'd10000, 1'b0, '0);
        add_row(1'b0, 16'd1000, 16'd0, 16'd1000, 32'd11999, 1'b0, '0);
        add_row(1'b0, 16'd1000, 16'd0, 16'd1000, 32'd12000, 1'b0, '0);
        add_row(1'b0, 16'd1000, 16'd0, 16'd1000, 32'd12999, 1'b0, '0);
        add_row(1'b0, 16'd1000, 16'd0, 16'd1000, 32'd13000, 1'b0, '0);
        add_row(1'b0, 16'd1000, 16'd0, 16'd1000, 32'd13001, 1'b0, '0);
        // timer across the 32-bit wrap, clear in the middle keeps the timer
        add_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FF00, 1'b0, '0);
        add_row(1'b0, 16'd500, 16'd0, 16'd400, 32'hFFFF_FF00, 1'b0, '0);
        add_row(1'b0, 16'd500, 16'd0, 16'd400, 32'h0000_06D0, 1'b0, '0);
        add_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                mk_res(ACT_NONE, DIR_S, 10'd0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        add_row(1'b0, 16'd500, 16'd0, 16'd400, 32'h0000_0AB8, 1'b0, '0);
        add_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, '0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row_idx = 0; row_idx < script_rows.size(); row_idx++) begin
            send_word(script_rows[row_idx].cmd, script_rows[row_idx].left_cm,
                      script_rows[row_idx].front_cm, script_rows[row_idx].right_cm,
                      script_rows[row_idx].now_ms, script_rows[row_idx].typed,
                      script_rows[row_idx].res);
        end
        stop_words();

        ms_now = '0;
        scene_left = 0;
        scene_mask = '0;
        for (phase = 0; phase < NUM_SETTINGS; phase++) begin
            drain(4);
            case (phase)
                0: load_limits(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h3FF, 32'h3FF);
                1: load_limits(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                2: load_limits(32'd300, 32'd50, 32'd500, 32'd100, 32'd777, 32'd1);
                3: load_limits(32'(RST_OBSTACLE), 32'(RST_CORNER), 32'(RST_STUCK),
                               32'(RST_ESCAPE), 32'(RST_TURN), 32'(RST_CRUISE));
                4: load_limits($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: load_limits($urandom_range(0, 200), $urandom_range(0, 200),
                                     $urandom_range(0, 3000), $urandom_range(0, 5000),
                                     $urandom_range(0, 1023), $urandom_range(0, 1023));
            endcase
            gaps_on   = (phase != 1);
            stalls_on = (phase != 1 && phase != 3);
            step_max  = ((limits.stuck_time_ms > limits.escape_time_ms) ?
                         32'(limits.stuck_time_ms) : 32'(limits.escape_time_ms)) / 4 + 2;
            if ($urandom_range(0, 1)) begin
                ms_now = $urandom;
            end
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (scene_left == 0) begin
                    scene_mask = ($urandom_range(0, 3) == 0) ? 3'b000 : 3'($urandom_range(0, 7));
                    scene_left = $urandom_range(1, 20);
                end
                scene_left--;
                if ($urandom_range(0, 29) == 0) begin
                    ms_now = $urandom;
                end else begin
                    ms_now = ms_now + $urandom_range(0, step_max);
                end
                rnd_cmd = ($urandom_range(0, 24) == 0);
                send_word(rnd_cmd, pick_dist(scene_mask[2]), pick_dist(scene_mask[1]),
                          pick_dist(scene_mask[0]), ms_now, 1'b0, '0);
            end
            stop_words();
        end

        drain(8);
        $display("ran %0d steps (%0d scripted) under %0d limit settings, %0d results compared",
                 words_sent, script_rows.size(), settings_done, results_seen);
        if (mismatches == 0) begin
            $display("obstacle_avoid_drive_controller_unit_tb OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("obstacle_avoid_drive_controller_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/oadc_pkg.sv
sv/oadc_apb_regs.sv
sv/obstacle_avoid_drive_controller_unit.sv
sim/obstacle_avoid_drive_controller_unit_tb.sv
